>>> sv/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion block
package rmq_pkg;
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 14;
	localparam int EPS_W      = 15;
	localparam int VEC_W      = 19;
	localparam int MAG_W      = 18;
	localparam int NORM_W     = 30;
	localparam int SHF_W      = 5;
	localparam int SQ_W       = 2 * NORM_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int RES_W      = SUM_W + 1;
	localparam int QUO_W      = FRAC_BITS + 1;
	localparam int NUM_W      = NORM_W + QUO_W;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] m00;
		logic signed [DATA_WIDTH-1:0] m01;
		logic signed [DATA_WIDTH-1:0] m02;
		logic signed [DATA_WIDTH-1:0] m10;
		logic signed [DATA_WIDTH-1:0] m11;
		logic signed [DATA_WIDTH-1:0] m12;
		logic signed [DATA_WIDTH-1:0] m20;
		logic signed [DATA_WIDTH-1:0] m21;
		logic signed [DATA_WIDTH-1:0] m22;
	} mat_t;

	// per-item control that rides along the pipeline
	typedef struct packed {
		logic [3:0] neg;
		branch_t    br;
		logic       zero;
	} tag_t;

	typedef struct packed {
		tag_t                         tag;
		logic [3:0][NORM_W-1:0]       mag;
	} side_t;
endpackage

>>> sv/rmq_if.sv
// request channels for matrices and quaternions
interface rmq_mat_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [rmq_pkg::DATA_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_quat_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [rmq_pkg::DATA_WIDTH-1:0] quat_w, quat_x, quat_y, quat_z;
	logic [1:0]                            branch_taken;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, branch_taken, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, branch_taken, output ready);
endinterface

>>> sv/rmq_front.sv
// branch select, block scaling and sum of squares
module rmq_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             valid,
	input  rmq_pkg::mat_t                    mat,
	input  logic [rmq_pkg::EPS_W-1:0]        eps,
	output logic                             valid_o,
	output logic [rmq_pkg::SUM_W-1:0]        sum_o,
	output rmq_pkg::side_t                   side_o
);
	localparam int VW = rmq_pkg::VEC_W;
	localparam int NW = rmq_pkg::NORM_W;

	logic signed [VW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, one, t, r;
	logic signed [3:0][VW-1:0] c;
	rmq_pkg::branch_t br;

	logic signed [3:0][VW-1:0] c_s1;
	rmq_pkg::branch_t          br_s1;
	logic                      v_s1, v_s2, v_s3, v_s4;

	logic [3:0][rmq_pkg::MAG_W-1:0] mag;
	logic [rmq_pkg::MAG_W-1:0]      mx;
	logic [rmq_pkg::SHF_W-1:0]      msb;
	logic [rmq_pkg::SHF_W-1:0]      shf;
	rmq_pkg::side_t                 side_s2, side_s3, side_s4;
	logic [3:0][rmq_pkg::SQ_W-1:0]  sq_s3;
	logic [rmq_pkg::SUM_W-1:0]      sum_s4;

	// stage 1: unnormalized vector
	always_comb begin
		a00 = VW'(mat.m00); a01 = VW'(mat.m01); a02 = VW'(mat.m02);
		a10 = VW'(mat.m10); a11 = VW'(mat.m11); a12 = VW'(mat.m12);
		a20 = VW'(mat.m20); a21 = VW'(mat.m21); a22 = VW'(mat.m22);
		one = VW'(1 << rmq_pkg::FRAC_BITS);
		t = a00 + a11 + a22;
		r = '0;
		if (t > $signed({{(VW-rmq_pkg::EPS_W){1'b0}}, eps})) begin
			br = rmq_pkg::BR_TRACE;
			c[0] = one + t;
			c[1] = a21 - a12;
			c[2] = a20 - a02;
			c[3] = a01 - a10;
		end else if (a00 > a11 && a00 > a22) begin
			br = rmq_pkg::BR_X;
			r = one + a00 - a11 - a22;
			c[0] = a21 - a12;
			c[1] = r[VW-1] ? '0 : r;
			c[2] = a01 + a10;
			c[3] = a20 + a02;
		end else if (a11 > a22) begin
			br = rmq_pkg::BR_Y;
			r = one + a11 - a00 - a22;
			c[0] = a20 - a02;
			c[1] = a01 + a10;
			c[2] = r[VW-1] ? '0 : r;
			c[3] = a21 + a12;
		end else begin
			br = rmq_pkg::BR_Z;
			r = one + a22 - a00 - a11;
			c[0] = a01 - a10;
			c[1] = a20 + a02;
			c[2] = a12 + a21;
			c[3] = r[VW-1] ? '0 : r;
		end
	end

	// stage 2: magnitudes shifted so the largest lands in [2^29, 2^30)
	always_comb begin
		mx = '0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = c_s1[i][VW-1] ? rmq_pkg::MAG_W'(-c_s1[i]) : rmq_pkg::MAG_W'(c_s1[i]);
			mx = mx | mag[i];
		end
		msb = '0;
		for (int b = 0; b < rmq_pkg::MAG_W; b++) begin
			if (mx[b]) msb = rmq_pkg::SHF_W'(b);
		end
		shf = rmq_pkg::SHF_W'(NW - 1) - msb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1  <= c;
			br_s1 <= br;
			side_s2.tag.br   <= br_s1;
			side_s2.tag.zero <= (mx == '0);
			for (int i = 0; i < 4; i++) begin
				side_s2.tag.neg[i] <= c_s1[i][VW-1];
				side_s2.mag[i]     <= NW'(mag[i]) << shf;
				sq_s3[i]           <= side_s2.mag[i] * side_s2.mag[i];
			end
			side_s3 <= side_s2;
			sum_s4  <= rmq_pkg::SUM_W'(sq_s3[0]) + rmq_pkg::SUM_W'(sq_s3[1])
				+ rmq_pkg::SUM_W'(sq_s3[2]) + rmq_pkg::SUM_W'(sq_s3[3]);
			side_s4 <= side_s3;
		end
	end

	assign valid_o = v_s4;
	assign sum_o   = sum_s4;
	assign side_o  = side_s4;
endmodule

>>> sv/rmq_isqrt.sv
// pipelined integer square root, one result bit per stage
module rmq_isqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid,
	input  logic [rmq_pkg::SUM_W-1:0]         sum,
	input  rmq_pkg::side_t                    side,
	output logic                              valid_o,
	output logic [rmq_pkg::ROOT_W-1:0]        root_o,
	output rmq_pkg::side_t                    side_o
);
	localparam int N  = rmq_pkg::ROOT_W;
	localparam int RW = rmq_pkg::RES_W;

	logic [rmq_pkg::SUM_W-1:0] rem_s  [0:N];
	logic [RW-1:0]             res_s  [0:N];
	rmq_pkg::side_t            side_s [0:N];
	logic [N:0]                v_s;

	assign rem_s[0]  = sum;
	assign res_s[0]  = '0;
	assign side_s[0] = side;
	assign v_s[0]    = valid;

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam int K = N - 1 - j;
		logic [RW-1:0] bitv, trial;
		logic          take;
		assign bitv  = RW'(1) << (2 * K);
		assign trial = res_s[j] + bitv;
		assign take  = RW'(rem_s[j]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= take ? rem_s[j] - rmq_pkg::SUM_W'(trial) : rem_s[j];
				res_s[j+1]  <= take ? (res_s[j] >> 1) + bitv : res_s[j] >> 1;
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign valid_o = v_s[N];
	assign root_o  = N'(res_s[N]);
	assign side_o  = side_s[N];
endmodule

>>> sv/rmq_div.sv
// four-lane pipelined rounding divide by the vector length
module rmq_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 valid,
	input  logic [rmq_pkg::ROOT_W-1:0]           len,
	input  rmq_pkg::side_t                       side,
	output logic                                 valid_o,
	output logic [3:0][rmq_pkg::QUO_W-1:0]       quo_o,
	output rmq_pkg::tag_t                        tag_o
);
	localparam int N  = rmq_pkg::QUO_W;
	localparam int NW = rmq_pkg::NUM_W;
	localparam int LW = rmq_pkg::ROOT_W;

	logic [3:0][NW-1:0]    rem_s [0:N];
	logic [3:0][N-1:0]     quo_s [0:N];
	logic [LW-1:0]         len_s [0:N];
	rmq_pkg::tag_t         tag_s [0:N];
	logic [N:0]            v_s;

	// numerator with half the divisor added for round half up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				rem_s[0][i] <= (NW'(side.mag[i]) << rmq_pkg::FRAC_BITS) + NW'(len >> 1);
			end
			quo_s[0] <= '0;
			len_s[0] <= len;
			tag_s[0] <= side.tag;
		end
	end

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam int K = N - 1 - j;
		logic [NW-1:0] dsh;
		assign dsh = NW'(len_s[j]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 4; i++) begin
					if (rem_s[j][i] >= dsh) begin
						rem_s[j+1][i]    <= rem_s[j][i] - dsh;
						quo_s[j+1][i]    <= quo_s[j][i] | (N'(1) << K);
					end else begin
						rem_s[j+1][i]    <= rem_s[j][i];
						quo_s[j+1][i]    <= quo_s[j][i];
					end
				end
				len_s[j+1] <= len_s[j];
				tag_s[j+1] <= tag_s[j];
			end
		end
	end

	assign valid_o = v_s[N];
	assign quo_o   = quo_s[N];
	assign tag_o   = tag_s[N];
endmodule

>>> sv/rotation_matrix_to_quaternion_top.sv
// top level: rotation matrix to unit quaternion, fully pipelined
// pipeline: front stages, then square root, divide and the output register
// throughput: one request per cycle; the whole pipeline advances when the output
//   register is empty or taken, so a stall freezes every stage in place
// reset: arst_n clears all valid bits and sets trace_epsilon to 2; data registers
//   are not reset
module rotation_matrix_to_quaternion_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rmq_pkg::EPS_W-1:0]  cfg_wdata,
	rmq_mat_if.sink                    mat,
	rmq_quat_if.source                 quat
);
	localparam int DW = rmq_pkg::DATA_WIDTH;

	logic [rmq_pkg::EPS_W-1:0] eps_q;
	logic                      en;
	rmq_pkg::mat_t             mat_in;

	logic                               f_valid, s_valid, d_valid;
	logic [rmq_pkg::SUM_W-1:0]          f_sum;
	rmq_pkg::side_t                     f_side, s_side;
	logic [rmq_pkg::ROOT_W-1:0]         s_root;
	logic [3:0][rmq_pkg::QUO_W-1:0]     d_quo;
	rmq_pkg::tag_t                      d_tag;

	logic                               out_valid_q;
	logic [3:0][DW-1:0]                 out_q;
	logic [3:0][DW-1:0]                 enc;
	logic [1:0]                         br_q;

	// trace threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= rmq_pkg::EPS_W'(2);
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	// global advance: output slot free or being emptied
	assign en        = !out_valid_q || quat.ready;
	assign mat.ready = en;

	assign mat_in = '{m00: mat.m00, m01: mat.m01, m02: mat.m02,
		m10: mat.m10, m11: mat.m11, m12: mat.m12,
		m20: mat.m20, m21: mat.m21, m22: mat.m22};

	// branch pick, vector build, scaling and squares
	rmq_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(mat.valid), .mat(mat_in), .eps(eps_q),
		.valid_o(f_valid), .sum_o(f_sum), .side_o(f_side)
	);

	// vector length
	rmq_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(f_valid), .sum(f_sum), .side(f_side),
		.valid_o(s_valid), .root_o(s_root), .side_o(s_side)
	);

	// per-component rounded divide
	rmq_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(s_valid), .len(s_root), .side(s_side),
		.valid_o(d_valid), .quo_o(d_quo), .tag_o(d_tag)
	);

	// sign restore and saturation; zero vector gives identity
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (d_tag.zero) begin
				enc[i] = (i == 0) ? DW'(1 << rmq_pkg::FRAC_BITS) : '0;
			end else if (d_tag.neg[i]) begin
				enc[i] = (DW'(d_quo[i]) > DW'(1 << (DW - 1))) ? DW'(1 << (DW - 1))
					: DW'(-DW'(d_quo[i]));
			end else begin
				enc[i] = (DW'(d_quo[i]) > DW'((1 << (DW - 1)) - 1)) ? DW'((1 << (DW - 1)) - 1)
					: DW'(d_quo[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= enc;
			br_q  <= d_tag.br;
		end
	end

	assign quat.valid        = out_valid_q;
	assign quat.quat_w       = out_q[0];
	assign quat.quat_x       = out_q[1];
	assign quat.quat_y       = out_q[2];
	assign quat.quat_z       = out_q[3];
	assign quat.branch_taken = br_q;

	// trace branch never has a negative scalar part
	a_trace_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.branch_taken == rmq_pkg::BR_TRACE |-> !quat.quat_w[DW-1])
		else $error("trace branch gave negative w");

	// dominant component of a diagonal branch is never negative
	a_diag_pos: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> !((quat.branch_taken == rmq_pkg::BR_X && quat.quat_x[DW-1])
			|| (quat.branch_taken == rmq_pkg::BR_Y && quat.quat_y[DW-1])
			|| (quat.branch_taken == rmq_pkg::BR_Z && quat.quat_z[DW-1])))
		else $error("dominant component negative");

	// a stalled output freezes the front of the pipeline too
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && !quat.ready |-> !mat.ready)
		else $error("request taken during output stall");
endmodule

>>> verif/rmq_test_if.sv
// expected-result type shared by the testbench
`timescale 1ns / 1ps
package rmq_test_pkg;
	// one expected quaternion result
	typedef struct {
		logic signed [rmq_pkg::DATA_WIDTH-1:0] w, x, y, z;
		rmq_pkg::branch_t                      br;
	} quat_exp_t;
endpackage

>>> verif/rotation_matrix_to_quaternion_top_test.sv
// self-checking testbench for the rotation matrix to quaternion block
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_top_test;
	localparam int LATENCY   = 52;
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 1530;
	localparam int DW        = rmq_pkg::DATA_WIDTH;
	localparam int EW        = rmq_pkg::EPS_W;
	localparam logic signed [DW-1:0] Q_ONE  = 16'sd16384;
	localparam logic signed [DW-1:0] Q_MAX  = 16'sh7fff;
	localparam logic signed [DW-1:0] Q_MIN  = 16'sh8000;
	localparam logic signed [DW-1:0] Q_ZERO = 16'sd0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [EW-1:0] cfg_wdata = '0;

	rmq_mat_if  mat();
	rmq_quat_if quat();

	rotation_matrix_to_quaternion_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.mat(mat.sink), .quat(quat.source)
	);

	// predictor copy of the threshold register
	logic [EW-1:0] eps_shadow = 15'd2;
	rmq_test_pkg::quat_exp_t expected_quats[$];
	int fail_count = 0;
	int idle_cycles = 0;
	bit in_quiet = 0;     // long stretch with no idling on either side
	bit hold_off = 0;     // receiver stalls for a long stretch

	initial begin
		forever #4 clk = ~clk;
	end

	// saturating sign and magnitude encode
	function automatic logic signed [DW-1:0] sat_encode(bit neg, longint unsigned mag);
		if (neg) begin
			if (mag > 64'd32768) mag = 64'd32768;
			return DW'(-$signed({1'b0, mag[16:0]}));
		end
		if (mag > 64'd32767) mag = 64'd32767;
		return mag[DW-1:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// shepperd branch choice, exact s*q vector, then block-scaled normalize
	function automatic rmq_test_pkg::quat_exp_t predict_quat(rmq_pkg::mat_t m);
		rmq_test_pkg::quat_exp_t q;
		longint c[4];
		logic signed [DW-1:0] o[4];
		longint unsigned mag[4], mx, sum, len, quo;
		bit neg[4];
		longint t, r;
		t = longint'(m.m00) + m.m11 + m.m22;
		if (t > longint'(eps_shadow)) begin
			q.br = rmq_pkg::BR_TRACE;
			c[0] = 16384 + t; c[1] = longint'(m.m21) - m.m12;
			c[2] = longint'(m.m20) - m.m02; c[3] = longint'(m.m01) - m.m10;
		end else if (m.m00 > m.m11 && m.m00 > m.m22) begin
			q.br = rmq_pkg::BR_X;
			r = 16384 + longint'(m.m00) - m.m11 - m.m22;
			c[0] = longint'(m.m21) - m.m12; c[1] = r < 0 ? 0 : r;
			c[2] = longint'(m.m01) + m.m10; c[3] = longint'(m.m20) + m.m02;
		end else if (m.m11 > m.m22) begin
			q.br = rmq_pkg::BR_Y;
			r = 16384 + longint'(m.m11) - m.m00 - m.m22;
			c[0] = longint'(m.m20) - m.m02; c[1] = longint'(m.m01) + m.m10;
			c[2] = r < 0 ? 0 : r; c[3] = longint'(m.m21) + m.m12;
		end else begin
			q.br = rmq_pkg::BR_Z;
			r = 16384 + longint'(m.m22) - m.m00 - m.m11;
			c[0] = longint'(m.m01) - m.m10; c[1] = longint'(m.m20) + m.m02;
			c[2] = longint'(m.m12) + m.m21; c[3] = r < 0 ? 0 : r;
		end
		mx = 0;
		for (int i = 0; i < 4; i++) begin
			neg[i] = c[i] < 0;
			mag[i] = neg[i] ? unsigned'(-c[i]) : unsigned'(c[i]);
			if (mag[i] > mx) mx = mag[i];
		end
		if (mx == 0) begin
			q.w = Q_ONE; q.x = '0; q.y = '0; q.z = '0;
			return q;
		end
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 4; i++) mag[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 4; i++) mag[i] <<= 1;
		end
		sum = 0;
		for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 4; i++) begin
			quo = ((mag[i] << rmq_pkg::FRAC_BITS) + (len >> 1)) / len;
			o[i] = sat_encode(neg[i], quo);
		end
		q.w = o[0]; q.x = o[1]; q.y = o[2]; q.z = o[3];
		return q;
	endfunction

	function automatic bit idle_roll();
		return !in_quiet && ($urandom_range(99) < 18);
	endfunction

	// request source: drive on falling edge, wait for handshake at rising edge;
	// valid stays high on return so back-to-back requests need no gap
	task automatic send_mat(rmq_pkg::mat_t m);
		while (idle_roll()) begin
			mat.valid <= 1'b0;
			@(negedge clk);
		end
		mat.valid <= 1'b1;
		{mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22} <= m;
		do @(posedge clk); while (!mat.ready);
		expected_quats.push_back(predict_quat(m));
		@(negedge clk);
	endtask

	task automatic drain_then_idle();
		mat.valid <= 1'b0;
		while (expected_quats.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_eps(logic [EW-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		eps_shadow = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [DW-1:0] rand_raw();
		return DW'($urandom());
	endfunction

	function automatic logic signed [DW-1:0] rand_entry();
		case ($urandom_range(5))
			0: return rand_raw();
			1: return Q_MAX;
			2: return Q_MIN;
			default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
		endcase
	endfunction

	// random matrix: usually diagonal from rand_entry values, off-diagonals in [-16384, 16383]; else all raw
	function automatic rmq_pkg::mat_t rand_mat();
		rmq_pkg::mat_t m;
		if ($urandom_range(9) < 2) begin
			m.m00 = rand_raw(); m.m01 = rand_raw(); m.m02 = rand_raw();
			m.m10 = rand_raw(); m.m11 = rand_raw(); m.m12 = rand_raw();
			m.m20 = rand_raw(); m.m21 = rand_raw(); m.m22 = rand_raw();
			if ($urandom_range(3) == 0) m.m01 = rand_entry();
			return m;
		end
		m.m00 = rand_entry(); m.m11 = rand_entry(); m.m22 = rand_entry();
		m.m01 = $signed(16'($urandom_range(32767))) - 16'sd16384;
		m.m02 = $signed(16'($urandom_range(32767))) - 16'sd16384;
		m.m10 = $signed(16'($urandom_range(32767))) - 16'sd16384;
		m.m12 = $signed(16'($urandom_range(32767))) - 16'sd16384;
		m.m20 = $signed(16'($urandom_range(32767))) - 16'sd16384;
		m.m21 = $signed(16'($urandom_range(32767))) - 16'sd16384;
		return m;
	endfunction

	// directed rows: matrix, whether the result is typed in, and that result
	typedef struct {
		rmq_pkg::mat_t           m;
		bit                      typed;
		rmq_test_pkg::quat_exp_t q;
	} dir_row_t;

	dir_row_t dir_rows[$];

	function automatic rmq_pkg::mat_t diag(logic signed [15:0] a, b, c);
		rmq_pkg::mat_t m;
		m = '0;
		m.m00 = a; m.m11 = b; m.m22 = c;
		return m;
	endfunction

	function automatic dir_row_t typed_row(rmq_pkg::mat_t m, logic signed [15:0] w, x, y, z,
		rmq_pkg::branch_t br);
		dir_row_t d;
		d.m = m; d.typed = 1;
		d.q.w = w; d.q.x = x; d.q.y = y; d.q.z = z; d.q.br = br;
		return d;
	endfunction

	function automatic dir_row_t pred_row(rmq_pkg::mat_t m);
		dir_row_t d;
		d.m = m; d.typed = 0;
		return d;
	endfunction

	// result checker: sample at rising edge, compare to the oldest expectation
	always @(posedge clk) begin
		rmq_test_pkg::quat_exp_t e;
		if (arst_n && quat.valid && quat.ready) begin
			if (expected_quats.size() == 0) begin
				$error("quaternion result with no request outstanding");
				fail_count++;
			end else begin
				e = expected_quats.pop_front();
				if (quat.quat_w !== e.w) begin
					$error("quat_w expected %0d actual %0d", e.w, quat.quat_w); fail_count++;
				end
				if (quat.quat_x !== e.x) begin
					$error("quat_x expected %0d actual %0d", e.x, quat.quat_x); fail_count++;
				end
				if (quat.quat_y !== e.y) begin
					$error("quat_y expected %0d actual %0d", e.y, quat.quat_y); fail_count++;
				end
				if (quat.quat_z !== e.z) begin
					$error("quat_z expected %0d actual %0d", e.z, quat.quat_z); fail_count++;
				end
				if (quat.branch_taken !== e.br) begin
					$error("branch_taken expected %0d actual %0d", e.br, quat.branch_taken);
					fail_count++;
				end
			end
		end
	end

	// receiver stall pattern on the falling edge
	initial begin
		quat.ready = 1'b0;
		forever begin
			@(negedge clk);
			quat.ready <= hold_off ? 1'b0 : !idle_roll();
		end
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((mat.valid && mat.ready) || (quat.valid && quat.ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("** rotation_matrix_to_quaternion_top: FAILED **");
			$finish;
		end
	end

	// main stimulus
	initial begin
		logic [EW-1:0] eps_list[5];
		rmq_pkg::mat_t m;
		mat.valid = 1'b0;
		{mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22} = '0;
		eps_list = '{15'd0, 15'd32767, 15'd16384, 15'd1, 15'd2};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at reset threshold
		dir_rows.push_back(typed_row(diag(Q_ONE, Q_ONE, Q_ONE), Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
			rmq_pkg::BR_TRACE));
		dir_rows.push_back(typed_row(diag(Q_ONE, -Q_ONE, -Q_ONE), Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO,
			rmq_pkg::BR_X));
		dir_rows.push_back(typed_row(diag(-Q_ONE, Q_ONE, -Q_ONE), Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO,
			rmq_pkg::BR_Y));
		dir_rows.push_back(typed_row(diag(-Q_ONE, -Q_ONE, Q_ONE), Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE,
			rmq_pkg::BR_Z));
		// most negative diagonal: ties fall to the z branch with a large radicand
		dir_rows.push_back(typed_row(diag(Q_MIN, Q_MIN, Q_MIN), Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE,
			rmq_pkg::BR_Z));
		dir_rows.push_back(typed_row(diag(Q_ZERO, Q_ZERO, Q_ZERO), Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE,
			rmq_pkg::BR_Z));
		dir_rows.push_back(pred_row(diag(Q_MAX, Q_MAX, Q_MAX)));
		dir_rows.push_back(pred_row(diag(16'sd1, 16'sd0, 16'sd1)));
		dir_rows.push_back(pred_row(diag(16'sd1, 16'sd1, 16'sd1)));
		dir_rows.push_back(pred_row(diag(16'sd2, 16'sd1, 16'sd0)));
		m = {9{Q_MAX}};
		dir_rows.push_back(pred_row(m));
		m = {9{Q_MIN}};
		dir_rows.push_back(pred_row(m));
		m = diag(Q_MIN, Q_MAX, Q_MIN);
		m.m01 = Q_MAX; m.m10 = Q_MIN; m.m02 = Q_MIN; m.m20 = Q_MAX; m.m12 = Q_MAX; m.m21 = Q_MIN;
		dir_rows.push_back(pred_row(m));
		m = diag(Q_ZERO, Q_ZERO, Q_ZERO);
		m.m01 = 16'sd11585; m.m10 = -16'sd11585;
		dir_rows.push_back(pred_row(m));
		m = diag(16'sd11585, 16'sd11585, Q_ONE);
		m.m01 = 16'sd11585; m.m10 = -16'sd11585;
		dir_rows.push_back(pred_row(m));
		foreach (dir_rows[i]) begin
			send_mat(dir_rows[i].m);
			if (dir_rows[i].typed) begin
				void'(expected_quats.pop_back());
				expected_quats.push_back(dir_rows[i].q);
			end
		end
		drain_then_idle();

		// random phases through several thresholds
		for (int ph = 0; ph < 5; ph++) begin
			write_eps(eps_list[ph]);
			for (int i = 0; i < N_RANDOM / 5; i++) begin
				in_quiet = (ph == 2) && (i < 150);
				if (ph == 1 && i == 40) begin
					// long receiver hold-off while the source keeps offering
					fork
						begin
							hold_off = 1;
							repeat (300) @(negedge clk);
							hold_off = 0;
						end
					join_none
				end
				if (ph == 3 && i == 100) begin
					// source pause until every result is back
					mat.valid <= 1'b0;
					@(negedge clk);
					while (expected_quats.size() != 0) @(negedge clk);
				end
				send_mat(rand_mat());
			end
			in_quiet = 0;
			drain_then_idle();
		end

		if (fail_count == 0 && expected_quats.size() == 0) begin
			$display("** rotation_matrix_to_quaternion_top: PASSED **");
		end else begin
			$display("** rotation_matrix_to_quaternion_top: FAILED **");
		end
		$finish;
	end
endmodule

>>> sim.f
sv/rmq_pkg.sv
sv/rmq_if.sv
sv/rmq_front.sv
sv/rmq_isqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion_top.sv
verif/rmq_test_if.sv
verif/rotation_matrix_to_quaternion_top_test.sv
